// File: sv/circular_next_mark_finder_assert.svh
// Assertion macros shared by the checker of the ring mark finder.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef CIRCULAR_NEXT_MARK_FINDER_ASSERT_SVH
`define CIRCULAR_NEXT_MARK_FINDER_ASSERT_SVH

// Same-cycle implication.
`define CNMF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CNMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cnmf_pkg.sv
package cnmf_pkg;

    // Ring capacity and field widths
    localparam int MAX_AREAS = 1024;
    localparam logic [31:0] MAX_AREAS_U = MAX_AREAS;
    localparam int ACT_W   = 2;
    localparam int AREA_W  = 11;
    localparam int STEPS_W = 31;
    localparam int DIST_W  = 10;

    // Internal widths derived from the capacity
    localparam int IDX_W  = $clog2(MAX_AREAS);
    localparam int N_W    = $clog2(MAX_AREAS + 1);
    localparam int WORD_W = 32;
    localparam int WBIT_W = $clog2(WORD_W);
    localparam int ROWS   = (MAX_AREAS + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Serial remainder unit: dividend holds position plus step count (move) or the position alone (query)
    localparam int DIV_W  = 32;
    localparam int ITER_W = $clog2(DIV_W + 1);

    localparam logic [AREA_W-1:0] AREA_COUNT_RST = AREA_W'(1024);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TOGGLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MOVE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TGL_RD,
        S_TGL_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [ITER_W-1:0] iters;
    } mod_req_t;

    // Clamp the written count into 1..MAX_AREAS
    function automatic logic [N_W-1:0] ring_size(input logic [AREA_W-1:0] cnt);
        logic [N_W-1:0] n;
        if (cnt == '0)
        begin
            n = N_W'(1);
        end
        else if (32'(cnt) > MAX_AREAS_U)
        begin
            n = N_W'(MAX_AREAS);
        end
        else
        begin
            n = N_W'(cnt);
        end
        return n;
    endfunction

endpackage

// File: sv/circular_next_mark_finder.sv
// Ring mark finder: areas 1..area_count on a ring, one mark per area, and a
// current position that starts at area 1.
// Input channel (in_valid / in_stall) carries one word: action, area, steps.
//   toggle flips the mark of an in-range area, move advances the position,
//   query returns the clockwise distance to the nearest marked area.
// Output channel (out_valid / out_stall) carries distance and none_marked,
//   one word per query only.
// Configuration: cfg_wr_en / cfg_wr_data write area_count; the user must write it only
// while idle, and the block itself does not enforce this. Work per word:
//   toggle: a row read, then the write back
//   move:   the 32-step serial remainder unit
//   query:  10 remainder steps, then one row read and one check per 32-bit
//           mark row, over up to ceil(n/32)+1 rows
//   ignored toggles and unused codes: no work, the block stays idle
// One word is in work at a time; in_stall is high while it is.
// A finished query result sits in the output register; a new word is taken
// while it waits, and the next result holds in the block until it is taken.
// Reset clears the position and all marks at once (one valid bit per row,
// no clearing pass) and sets area_count to 1024.
module circular_next_mark_finder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cnmf_pkg::ACT_W-1:0]    action,
    input  logic [cnmf_pkg::AREA_W-1:0]   area,
    input  logic [cnmf_pkg::STEPS_W-1:0]  steps,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cnmf_pkg::DIST_W-1:0]   distance,
    output logic                          none_marked,
    input  logic                          cfg_wr_en,
    input  logic [cnmf_pkg::AREA_W-1:0]   cfg_wr_data
);
    import cnmf_pkg::*;

    state_t state_reg, state_next;

    logic [AREA_W-1:0] area_count_reg;
    logic [IDX_W-1:0]  position_reg, position_next;
    logic              is_query_reg, is_query_next;
    logic [IDX_W-1:0]  tidx_reg, tidx_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W:0]    left_reg, left_next;
    logic              first_reg, first_next;
    logic              wrap_reg, wrap_next;
    logic [N_W-1:0]    res_dist_reg, res_dist_next;
    logic              res_none_reg, res_none_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] dist_out_reg, dist_out_next;
    logic              none_out_reg, none_out_next;

    // Mark store: rows of 32 marks, one valid bit per row
    logic [WORD_W-1:0] mark_mem [ROWS];
    logic [ROWS-1:0]   row_vld_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [ROW_W-1:0]  rd_addr;
    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] word_q;

    mod_req_t          mod_req;
    logic              mod_done;
    logic [N_W-1:0]    mod_rem;

    logic [N_W-1:0]    ring_n;
    logic [ROW_W-1:0]  last_row;
    logic              accept;
    logic              tgl_ok;
    logic              out_free;
    logic [31:0]       row_base;
    logic [31:0]       row_lim;
    logic [WORD_W-1:0] hit;
    logic              found;
    logic [WBIT_W-1:0] hit_bit;
    logic [N_W-1:0]    idx_hit;
    logic [N_W-1:0]    hit_dist;

    cnmf_serial_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mod_req),
        .divisor (ring_n),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    assign ring_n   = ring_size(area_count_reg);
    assign last_row = ROW_W'((ring_n - N_W'(1)) >> WBIT_W);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign tgl_ok   = (area != '0) && (32'(area) <= 32'(ring_n));
    assign out_free = !out_valid_reg || !out_stall;

    // Rows never written read as all clear
    assign word_q = rd_vld_reg ? rd_data_reg : '0;

    // Scan one row: drop marks past the ring end, and below the start on the first row
    assign row_base = 32'(row_reg) << WBIT_W;
    assign row_lim  = 32'(ring_n) - row_base;

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            hit[j] = word_q[j] && (32'(j) < row_lim) &&
                     (!first_reg || (WBIT_W'(j) >= WBIT_W'(p_reg)));
        end
    end

    // Lowest hit wins
    always_comb
    begin
        found   = 1'b0;
        hit_bit = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                found   = 1'b1;
                hit_bit = WBIT_W'(j);
            end
        end
    end

    assign idx_hit  = N_W'(row_base | 32'(hit_bit));
    // After a wrap the hit lies below the start: add the ring size back
    assign hit_dist = wrap_reg ? (ring_n - N_W'(p_reg)) + idx_hit
                               : idx_hit - N_W'(p_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action) inside
                        ACT_TOGGLE:           state_next = tgl_ok ? S_TGL_RD : S_IDLE;
                        ACT_MOVE, ACT_QUERY:  state_next = S_MOD;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = is_query_reg ? S_SCAN_RD : S_IDLE;
                end
            end
            S_TGL_RD:   state_next = S_TGL_WR;
            S_TGL_WR:   state_next = S_IDLE;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: state_next = (found || left_reg == '0) ? S_DONE : S_SCAN_RD;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and control outputs
    always_comb
    begin
        position_next  = position_reg;
        is_query_next  = is_query_reg;
        tidx_next      = tidx_reg;
        p_next         = p_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        first_next     = first_reg;
        wrap_next      = wrap_reg;
        res_dist_next  = res_dist_reg;
        res_none_next  = res_none_reg;
        out_valid_next = out_valid_reg;
        dist_out_next  = dist_out_reg;
        none_out_next  = none_out_reg;
        mod_req        = '0;
        mem_we         = 1'b0;
        mem_waddr      = ROW_W'(tidx_reg >> WBIT_W);
        mem_wdata      = word_q ^ (WORD_W'(1) << WBIT_W'(tidx_reg));
        rd_addr        = (state_reg == S_TGL_RD) ? ROW_W'(tidx_reg >> WBIT_W) : row_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    is_query_next = (action == ACT_QUERY);
                    tidx_next     = IDX_W'(area - AREA_W'(1));
                    if (action == ACT_QUERY)
                    begin
                        // Reduce the position only: feed its bits at the top
                        mod_req.start    = 1'b1;
                        mod_req.dividend = DIV_W'(position_reg) << (DIV_W - IDX_W);
                        mod_req.iters    = ITER_W'(IDX_W);
                    end
                    else if (action == ACT_MOVE)
                    begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = DIV_W'(position_reg) + DIV_W'(steps);
                        mod_req.iters    = ITER_W'(DIV_W);
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    if (is_query_reg)
                    begin
                        p_next     = IDX_W'(mod_rem);
                        row_next   = ROW_W'(mod_rem >> WBIT_W);
                        left_next  = {1'b0, last_row} + (ROW_W + 1)'(1);
                        first_next = 1'b1;
                        wrap_next  = 1'b0;
                    end
                    else
                    begin
                        position_next = IDX_W'(mod_rem);
                    end
                end
            end
            S_TGL_RD:
            begin
            end
            S_TGL_WR:
            begin
                mem_we = 1'b1;
            end
            S_SCAN_RD:
            begin
            end
            S_SCAN_CHK:
            begin
                if (found)
                begin
                    res_dist_next = hit_dist;
                    res_none_next = 1'b0;
                end
                else if (left_reg == '0)
                begin
                    res_dist_next = '0;
                    res_none_next = 1'b1;
                end
                else
                begin
                    // Advance one row, wrapping at the ring end
                    left_next  = left_reg - (ROW_W + 1)'(1);
                    first_next = 1'b0;
                    if (row_reg == last_row)
                    begin
                        row_next  = '0;
                        wrap_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dist_out_next  = DIST_W'(res_dist_reg);
                    none_out_next  = res_none_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            area_count_reg <= AREA_COUNT_RST;
            position_reg   <= '0;
            out_valid_reg  <= 1'b0;
            row_vld_reg    <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= row_vld_reg[rd_addr];
            if (cfg_wr_en)
            begin
                area_count_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                row_vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        is_query_reg <= is_query_next;
        tidx_reg     <= tidx_next;
        p_reg        <= p_next;
        row_reg      <= row_next;
        left_reg     <= left_next;
        first_reg    <= first_next;
        wrap_reg     <= wrap_next;
        res_dist_reg <= res_dist_next;
        res_none_reg <= res_none_next;
        dist_out_reg <= dist_out_next;
        none_out_reg <= none_out_next;
    end

    // Mark memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mark_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mark_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign distance    = dist_out_reg;
    assign none_marked = none_out_reg;

endmodule

// File: sv/cnmf_serial_mod.sv
module cnmf_serial_mod (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cnmf_pkg::mod_req_t      req,
    input  logic [cnmf_pkg::N_W-1:0] divisor,
    output logic                    done,
    output logic [cnmf_pkg::N_W-1:0] rem
);
    import cnmf_pkg::*;

    logic [DIV_W-1:0]  shift_reg, shift_next;
    logic [N_W-1:0]    rem_reg, rem_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [N_W:0]      trial;
    logic [N_W:0]      trial_sub;

    // One dividend bit per cycle: shift in, subtract divisor if it fits
    assign trial     = {rem_reg, shift_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, divisor};

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        iter_next  = iter_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            shift_next = req.dividend;
            rem_next   = '0;
            iter_next  = req.iters;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[DIV_W-2:0], 1'b0};
            rem_next   = (trial >= {1'b0, divisor}) ? N_W'(trial_sub) : N_W'(trial);
            iter_next  = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: sv/cnmf_checker.sv
`include "circular_next_mark_finder_assert.svh"

module cnmf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [cnmf_pkg::ACT_W-1:0]    action,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [cnmf_pkg::DIST_W-1:0]   distance,
    input logic                          none_marked
);
    import cnmf_pkg::*;

    // Hold a stalled result word
    `CNMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance) && $stable(none_marked), "stalled result word changed")

    // An empty ring reports zero distance
    `CNMF_ASSERT_IMPLY(a_none_zero, out_valid && none_marked, distance == '0, "none_marked with nonzero distance")

    // A query keeps the input side busy
    `CNMF_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && action == ACT_QUERY, in_stall, "input taken right after a query")

    // A query result cannot show up the cycle after the query is taken
    `CNMF_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall && action == ACT_QUERY, !$rose(out_valid), "result rose too early")

endmodule

bind circular_next_mark_finder cnmf_checker u_cnmf_checker (.*);

// File: verif/tb_circular_next_mark_finder.sv
module tb_circular_next_mark_finder;

    import cnmf_pkg::*;

    // Unused action code; the block drops it without a result
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RESET_CYCLES = 11;
    // Worst case for one word is a full-ring query
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_WORDS   = 118;
    localparam int POOL_SIZE     = 6;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [AREA_W-1:0]  area;
        logic [STEPS_W-1:0] steps;
    } ring_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] mark_dist;
        logic              no_mark;
    } nearest_mark_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACT_W-1:0]    action = '0;
    logic [AREA_W-1:0]   area = '0;
    logic [STEPS_W-1:0]  steps = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DIST_W-1:0]   distance;
    logic                none_marked;
    logic                cfg_wr_en = 1'b0;
    logic [AREA_W-1:0]   cfg_wr_data = '0;

    // Shadow state of the ring
    bit                  ring_marks [MAX_AREAS];
    logic [IDX_W-1:0]    ring_pos;
    logic [AREA_W-1:0]   area_count_reg;

    ring_word_t          pending_words [$];
    nearest_mark_t       nearest_due [$];
    int unsigned         area_pool [POOL_SIZE];

    int                  send_gap = 0;
    int                  take_gap = 0;
    int                  hold_left = 0;
    logic                hold_kick = 1'b0;
    logic                calm = 1'b0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;

    circular_next_mark_finder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .area        (area),
        .steps       (steps),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance    (distance),
        .none_marked (none_marked),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // Clamp the raw register into the ring size actually in use
    function automatic int unsigned ring_len(input logic [AREA_W-1:0] raw);
        int unsigned n;
        n = 32'(raw);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > MAX_AREAS)
        begin
            n = MAX_AREAS;
        end
        return n;
    endfunction

    // Advance the shadow ring by one accepted word; queue the answer of a query
    function automatic void advance_ring(input ring_word_t w);
        int unsigned   n;
        int unsigned   p;
        int unsigned   idx;
        bit            found;
        nearest_mark_t res;
        n = ring_len(area_count_reg);
        p = ring_pos % n;
        found = 1'b0;
        res = '0;
        case (w.action)
            ACT_TOGGLE:
            begin
                // drop toggles of area 0 and of areas past the ring
                if (w.area >= 1 && w.area <= n)
                begin
                    ring_marks[w.area - 1] = ~ring_marks[w.area - 1];
                end
            end
            ACT_MOVE:
            begin
                ring_pos = IDX_W'((p + (32'(w.steps) % n)) % n);
            end
            ACT_QUERY:
            begin
                // scan clockwise from the current area; marks past the ring are ignored
                for (int unsigned d = 0; d < n; d++)
                begin
                    idx = (p + d) % n;
                    if (!found && ring_marks[idx])
                    begin
                        found = 1'b1;
                        res.mark_dist = DIST_W'(d);
                    end
                end
                res.no_mark = !found;
                nearest_due.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic void push_word(input logic [ACT_W-1:0] act,
                                      input int unsigned ar,
                                      input int unsigned st);
        ring_word_t w;
        w.action = act;
        w.area = AREA_W'(ar);
        w.steps = STEPS_W'(st);
        pending_words.push_back(w);
    endfunction

    // Mostly well-formed traffic: toggles drawn from a small pool keep the
    // ring sparse, so queries see long and varied distances
    function automatic ring_word_t random_word(input int unsigned n);
        ring_word_t  w;
        int unsigned pick;
        int unsigned sub;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        w.area = AREA_W'($urandom_range(0, 2047));
        w.steps = STEPS_W'($urandom);
        if (pick < 38)
        begin
            w.action = ACT_TOGGLE;
            if (sub < 75)
            begin
                w.area = AREA_W'(area_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end
            else if (sub < 90)
            begin
                w.area = AREA_W'($urandom_range(1, n));
            end
        end
        else if (pick < 62)
        begin
            w.action = ACT_MOVE;
            if (sub < 50)
            begin
                w.steps = STEPS_W'($urandom_range(0, 2 * n));
            end
        end
        else if (pick < 96)
        begin
            w.action = ACT_QUERY;
        end
        else
        begin
            w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    // Wait until every word is taken and every answer is back, then let the
    // block finish whatever toggle or move is still in work
    task automatic settle();
        while (pending_words.size() != 0 || in_valid || nearest_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_area_count(input int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= AREA_W'(value);
        @(posedge clk);
        // the block takes the write at this edge
        area_count_reg = AREA_W'(value);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender: hold each word until taken, then wait a drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin : drive
        int         gap_now;
        bit         word_done;
        ring_word_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            area <= '0;
            steps <= '0;
            send_gap <= 0;
        end
        else
        begin
            word_done = in_valid && !in_stall;
            gap_now = send_gap;
            if (word_done)
            begin
                advance_ring('{action, area, steps});
                gap_now = calm ? 0 : $urandom_range(0, 10);
            end
            if (!in_valid || word_done)
            begin
                if (gap_now == 0 && pending_words.size() != 0)
                begin
                    nxt = pending_words.pop_front();
                    action <= nxt.action;
                    area <= nxt.area;
                    steps <= nxt.steps;
                    in_valid <= 1'b1;
                    send_gap <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    send_gap <= (gap_now > 0) ? gap_now - 1 : 0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_kick)
        begin
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: check each taken result against the oldest answer due
    always @(posedge clk or negedge rst_n)
    begin : watch
        int            nw;
        nearest_mark_t due;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (nearest_due.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing due: distance %0d none_marked %0b",
                                              distance, none_marked));
                end
                else
                begin
                    due = nearest_due.pop_front();
                    if (distance !== due.mark_dist)
                    begin
                        report_mismatch($sformatf("distance %0d, want %0d",
                                                  distance, due.mark_dist));
                    end
                    if (none_marked !== due.no_mark)
                    begin
                        report_mismatch($sformatf("none_marked %0b, want %0b",
                                                  none_marked, due.no_mark));
                    end
                end
                nw = calm ? 0 : $urandom_range(0, 10);
            end
            else
            begin
                nw = (take_gap > 0) ? take_gap - 1 : 0;
            end
            take_gap <= nw;
            out_stall <= (nw != 0) || (hold_left != 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : run
        int unsigned counts [] = '{1024, 1, 0, 2, 7, 33, 2047, 1023, 100, 1025, 5, 1024};
        int unsigned n;
        for (int i = 0; i < MAX_AREAS; i++)
        begin
            ring_marks[i] = 1'b0;
        end
        ring_pos = '0;
        area_count_reg = AREA_COUNT_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty ring, farthest mark, ignored toggles, unused code,
        // step count extremes, wrap of the position
        write_area_count(1024);
        push_word(ACT_QUERY, 0, 0);
        push_word(ACT_TOGGLE, 1024, 0);
        push_word(ACT_QUERY, 2047, 31'h7FFFFFFF);
        push_word(ACT_TOGGLE, 1, 0);
        push_word(ACT_QUERY, 0, 0);
        push_word(ACT_TOGGLE, 0, 0);
        push_word(ACT_TOGGLE, 1025, 0);
        push_word(ACT_TOGGLE, 2047, 31'h7FFFFFFF);
        push_word(ACT_UNUSED, 2047, 31'h7FFFFFFF);
        push_word(ACT_MOVE, 0, 0);
        push_word(ACT_QUERY, 0, 0);
        push_word(ACT_MOVE, 2047, 1);
        push_word(ACT_QUERY, 0, 0);
        push_word(ACT_MOVE, 0, 31'h7FFFFFFF);
        push_word(ACT_QUERY, 0, 0);
        push_word(ACT_TOGGLE, 1, 0);
        push_word(ACT_TOGGLE, 1024, 0);
        push_word(ACT_QUERY, 0, 0);
        push_word(ACT_TOGGLE, 512, 0);
        push_word(ACT_MOVE, 0, 1000);
        push_word(ACT_QUERY, 0, 0);
        push_word(ACT_UNUSED, 0, 0);
        push_word(ACT_QUERY, 0, 0);
        settle();

        // Random phases over ring sizes; marks and position carry across,
        // so shrinking the ring leaves marks and a position past its end
        foreach (counts[ph])
        begin
            write_area_count(counts[ph]);
            n = ring_len(AREA_W'(counts[ph]));
            foreach (area_pool[k])
            begin
                area_pool[k] = $urandom_range(1, n);
            end
            calm <= (ph == 3 || ph == 10);
            if (ph == 8)
            begin
                // hold the output long enough for the block to stall its input
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                pending_words.push_back(random_word(n));
            end
            settle();
        end

        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
